// ===== hw/rtl/srcp_pkg.sv =====
// ----------------------------------------------------------------------------
// srcp_pkg: shared types and constants of the sample record call-chain parser
// holds the queue entry passed from the parser front to the result back end
// ----------------------------------------------------------------------------
package srcp_pkg;

    // default cap on the entries copied from one record
    localparam int unsigned MAX_DEPTH_DEF = 255;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_BRANCH_MODE = 1'b0;
    localparam logic CFG_MAX_DEPTH   = 1'b1;

    // reset value of max_depth
    localparam logic [7:0] MAX_DEPTH_RESET = 8'd127;

    // result kinds
    localparam logic KIND_ADDR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one parsed word: up to one address result and one summary result
    typedef struct packed {
        logic        has_addr;
        logic        has_sum;
        logic [63:0] addr;
        logic [63:0] ip;
        logic [31:0] pid;
        logic [31:0] tid;
        logic [7:0]  depth;
    } t_entry;

endpackage

// ===== hw/rtl/srcp_front.sv =====
// ----------------------------------------------------------------------------
// srcp_front: record word parser
// walks header, ip, pid/tid, count and entry words and queues the results
// ----------------------------------------------------------------------------
module srcp_front #(
    parameter int unsigned MAX_DEPTH = srcp_pkg::MAX_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [63:0]        i_word,
    input  logic               i_start,
    input  logic               i_cfg_wen,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_push,
    output srcp_pkg::t_entry   o_entry
);

    localparam logic [7:0] LimCap = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_IP     = 6'b000010,
        PH_PIDTID = 6'b000100,
        PH_COUNT  = 6'b001000,
        PH_PLAIN  = 6'b010000,
        PH_BRANCH = 6'b100000
    } t_phase;

    logic        r_branch_mode;
    logic [7:0]  r_max_depth;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_bytes,   n_bytes;
    logic [63:0] r_ip,      n_ip;
    logic [31:0] r_pid,     n_pid;
    logic [31:0] r_tid,     n_tid;
    logic [7:0]  r_copy,    n_copy;
    logic [7:0]  r_seen,    n_seen;
    logic [1:0]  r_pos,     n_pos;
    logic [7:0]  r_emitted, n_emitted;
    logic [11:0] r_room_br;

    logic [12:0] total;
    logic [12:0] room_plain;
    logic [12:0] room;
    logic [28:0] room_prod;
    logic [12:0] cnt_room;
    logic [7:0]  limit;
    logic [7:0]  cnt;
    logic [7:0]  seen_inc;
    logic        has_addr;
    logic        has_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch_mode <= 1'b0;
            r_max_depth   <= srcp_pkg::MAX_DEPTH_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                srcp_pkg::CFG_BRANCH_MODE: r_branch_mode <= i_cfg_wdata[0];
                srcp_pkg::CFG_MAX_DEPTH:   r_max_depth   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign total      = r_bytes[15:3];
    assign room_plain = total - 13'd4;
    // (total - 4) / 3 by reciprocal, settles before the count word arrives
    assign room_prod  = 29'(room_plain) * 29'd43691;

    always_ff @(posedge i_clk) begin
        r_room_br <= room_prod[28:17];
    end

    assign room     = r_branch_mode ? {1'b0, r_room_br} : room_plain;
    assign cnt_room = ((i_word[63:13] == 51'd0) && (i_word[12:0] < room)) ? i_word[12:0] : room;
    assign limit    = (r_max_depth < LimCap) ? r_max_depth : LimCap;
    assign cnt      = (cnt_room > 13'(limit)) ? limit : cnt_room[7:0];
    assign seen_inc = r_seen + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_bytes   = r_bytes;
        n_ip      = r_ip;
        n_pid     = r_pid;
        n_tid     = r_tid;
        n_copy    = r_copy;
        n_seen    = r_seen;
        n_pos     = r_pos;
        n_emitted = r_emitted;
        has_addr  = 1'b0;
        has_sum   = 1'b0;
        if (i_accept) begin
            if (i_start) begin
                n_bytes   = i_word[63:48];
                n_ip      = '0;
                n_pid     = '0;
                n_tid     = '0;
                n_copy    = '0;
                n_seen    = '0;
                n_pos     = '0;
                n_emitted = '0;
                n_phase   = PH_IP;
                if (i_word[63:52] == 12'd0) begin
                    has_sum = 1'b1;
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_IP: begin
                        n_ip    = i_word;
                        n_phase = PH_PIDTID;
                        if (total < 13'd3) begin
                            has_sum = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_PIDTID: begin
                        n_pid   = i_word[31:0];
                        n_tid   = i_word[63:32];
                        n_phase = PH_COUNT;
                        if (total < 13'd4) begin
                            has_sum = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_COUNT: begin
                        n_copy  = cnt;
                        n_seen  = '0;
                        n_pos   = '0;
                        n_phase = r_branch_mode ? PH_BRANCH : PH_PLAIN;
                        if (cnt == 8'd0) begin
                            has_sum = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_PLAIN: begin
                        has_addr  = 1'b1;
                        n_emitted = r_emitted + 8'd1;
                        n_seen    = seen_inc;
                        if (seen_inc == r_copy) begin
                            has_sum = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BRANCH: begin
                        case (r_pos)
                            2'd0: begin
                                if (i_word != 64'd0) begin
                                    has_addr  = 1'b1;
                                    n_emitted = r_emitted + 8'd1;
                                end
                                n_seen = seen_inc;
                                n_pos  = 2'd1;
                                if (seen_inc == r_copy) begin
                                    has_sum = 1'b1;
                                    n_phase = PH_IDLE;
                                end
                            end
                            2'd1:    n_pos = 2'd2;
                            default: n_pos = 2'd0;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bytes   <= '0;
            r_ip      <= '0;
            r_pid     <= '0;
            r_tid     <= '0;
            r_copy    <= '0;
            r_seen    <= '0;
            r_pos     <= '0;
            r_emitted <= '0;
        end else begin
            r_phase   <= n_phase;
            r_bytes   <= n_bytes;
            r_ip      <= n_ip;
            r_pid     <= n_pid;
            r_tid     <= n_tid;
            r_copy    <= n_copy;
            r_seen    <= n_seen;
            r_pos     <= n_pos;
            r_emitted <= n_emitted;
        end
    end

    assign o_push           = has_addr | has_sum;
    assign o_entry.has_addr = has_addr;
    assign o_entry.has_sum  = has_sum;
    assign o_entry.addr     = i_word;
    assign o_entry.ip       = n_ip;
    assign o_entry.pid      = n_pid;
    assign o_entry.tid      = n_tid;
    assign o_entry.depth    = n_emitted;

endmodule

// ===== hw/rtl/srcp_queue.sv =====
// ----------------------------------------------------------------------------
// srcp_queue: short entry queue
// decouples the parser front from the result back end
// ----------------------------------------------------------------------------
module srcp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  srcp_pkg::t_entry   i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output srcp_pkg::t_entry   o_entry
);

    localparam int unsigned Depth = srcp_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    srcp_pkg::t_entry r_mem [Depth];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntW-1:0]  r_count;

    logic do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CntW'(Depth));
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/srcp_back.sv =====
// ----------------------------------------------------------------------------
// srcp_back: result back end
// expands each queue entry into its address and summary results
// ----------------------------------------------------------------------------
module srcp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  srcp_pkg::t_entry   i_q_entry,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic               o_last,
    output logic [63:0]        o_addr,
    output logic [63:0]        o_ip,
    output logic [31:0]        o_pid,
    output logic [31:0]        o_tid,
    output logic [7:0]         o_depth
);

    logic        r_valid;
    logic        r_addr_sent;
    logic        r_kind;
    logic [63:0] r_addr;
    logic [63:0] r_ip;
    logic [31:0] r_pid;
    logic [31:0] r_tid;
    logic [7:0]  r_depth;

    logic load;
    logic send_addr;

    assign load      = i_q_valid && (!r_valid || i_ready);
    assign send_addr = i_q_entry.has_addr && !r_addr_sent;
    assign o_q_pop   = load && (!send_addr || !i_q_entry.has_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_addr_sent <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_addr_sent <= send_addr && i_q_entry.has_sum;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= send_addr ? srcp_pkg::KIND_ADDR : srcp_pkg::KIND_SUMMARY;
            r_addr  <= send_addr ? i_q_entry.addr : 64'd0;
            r_ip    <= i_q_entry.ip;
            r_pid   <= i_q_entry.pid;
            r_tid   <= i_q_entry.tid;
            r_depth <= i_q_entry.depth;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_last  = (r_kind == srcp_pkg::KIND_SUMMARY);
    assign o_addr  = r_addr;
    assign o_ip    = r_ip;
    assign o_pid   = r_pid;
    assign o_tid   = r_tid;
    assign o_depth = r_depth;

endmodule

// ===== hw/rtl/sample_record_callchain_parser_unit.sv =====
// ----------------------------------------------------------------------------
// sample_record_callchain_parser_unit: profiler sample record call-chain parser
// turns 64-bit record words into stack address results and record summaries
// ----------------------------------------------------------------------------
// The unit takes one 64-bit record word per cycle on the slave stream; tuser
// marks the header word, whose bits 63..48 give the record size in bytes. The
// parser front handles every word combinationally with counters and compares
// and queues up to two results per word in a four-entry queue. The back end
// drains that queue into a registered master stream at one result per cycle,
// so input runs at one word per cycle while the output keeps up, and a word
// that yields both an address and the closing summary is sent as two results,
// address first. Address results come with tuser = 0; the summary that closes
// each record comes with tuser = 1 and tlast high. branch_mode and max_depth are
// sampled on the count word of each record and should be written while idle.
// ----------------------------------------------------------------------------
module sample_record_callchain_parser_unit #(
    parameter int unsigned MAX_DEPTH = srcp_pkg::MAX_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_wen,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_wdata,
    // record words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // data_word
    input  logic [0:0]   s_axis_tuser,   // record_start
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // stack_address[63:0], sample_ip[127:64], process_id[159:128],
    // thread_id[191:160], stack_depth[199:192]
    output logic [199:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // record_done
);

    srcp_pkg::t_entry push_entry;
    srcp_pkg::t_entry head_entry;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             accept;
    logic             res_kind;
    logic [63:0]      res_addr;
    logic [63:0]      res_ip;
    logic [31:0]      res_pid;
    logic [31:0]      res_tid;
    logic [7:0]       res_depth;

    // a word is taken whenever the queue has room for its results
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // parser front: phase tracking, copy count and address selection
    srcp_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (s_axis_tdata),
        .i_start     (s_axis_tuser[0]),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // entry queue between front and back
    srcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // back end: one result per cycle into the output register while the output is taken
    srcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (res_kind),
        .o_last    (m_axis_tlast),
        .o_addr    (res_addr),
        .o_ip      (res_ip),
        .o_pid     (res_pid),
        .o_tid     (res_tid),
        .o_depth   (res_depth)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata    = {res_depth, res_tid, res_pid, res_ip, res_addr};
    assign m_axis_tuser[0] = res_kind;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sample record call-chain parser unit
// streams sample records through the unit, predicts every stack address and
// record summary in the bench, and compares them field by field on the output
// ----------------------------------------------------------------------------
module tb_top;
    import srcp_pkg::*;

    // entry cap handed to the unit, same value the predictor works with
    localparam int unsigned DEPTH_CAP     = MAX_DEPTH_DEF;
    // queue depth plus output register, with margin
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // chance in a hundred that a side stalls on a given cycle
    localparam int unsigned IDLE_PCT      = 35;
    localparam int unsigned MAX_REPORTS   = 40;

    // where the predictor stands inside the current record
    typedef enum logic [2:0] {
        WAIT_HEADER,
        READ_IP,
        READ_PIDTID,
        READ_COUNT,
        COPY_PLAIN,
        COPY_BRANCH
    } t_record_step;

    // one result as it should leave the unit
    typedef struct packed {
        logic        kind;
        logic [63:0] addr;
        logic [63:0] ip;
        logic [31:0] pid;
        logic [31:0] tid;
        logic [7:0]  depth;
        logic        done;
    } t_stack_result;

    // ------------------------------------------------------------------
    // unit ports, all inputs driven to known values from time zero
    // ------------------------------------------------------------------
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_wen     = 1'b0;
    logic         i_cfg_index   = CFG_BRANCH_MODE;
    logic [7:0]   i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;   // data_word
    logic [0:0]   s_axis_tuser  = '0;   // record_start
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // stack_address[63:0], sample_ip[127:64], process_id[159:128],
    // thread_id[191:160], stack_depth[199:192]
    logic [199:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;         // result_kind
    logic         m_axis_tlast;         // record_done

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    // both sides stop stalling while this is set
    logic         steady_flow = 1'b0;

    // the bench's own copy of the configuration registers
    logic         cfg_branch    = 1'b0;
    logic [7:0]   cfg_max_depth = MAX_DEPTH_RESET;

    // parser state as the predictor tracks it
    t_record_step rec_step   = WAIT_HEADER;
    logic [15:0]  rec_size   = '0;
    logic [63:0]  held_ip    = '0;
    logic [31:0]  held_pid   = '0;
    logic [31:0]  held_tid   = '0;
    logic [7:0]   copy_count = '0;
    logic [7:0]   copied     = '0;
    logic [1:0]   entry_pos  = '0;
    logic [7:0]   emitted    = '0;

    // results still owed by the unit, oldest first
    t_stack_result results_due[$];

    int unsigned  words_sent      = 0;
    int unsigned  records_sent    = 0;
    int unsigned  addrs_checked   = 0;
    int unsigned  summaries_seen  = 0;
    int unsigned  mismatches      = 0;
    int unsigned  cycle_count     = 0;

    // ------------------------------------------------------------------
    // unit under test
    // ------------------------------------------------------------------
    sample_record_callchain_parser_unit #(
        .MAX_DEPTH(DEPTH_CAP)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // queue one result built from the fields held so far
    task automatic push_result(input logic kind, input logic [63:0] addr);
        t_stack_result r;
        r.kind  = kind;
        r.addr  = (kind == KIND_SUMMARY) ? 64'd0 : addr;
        r.ip    = held_ip;
        r.pid   = held_pid;
        r.tid   = held_tid;
        r.depth = emitted;
        r.done  = (kind == KIND_SUMMARY);
        results_due.push_back(r);
    endtask

    // summary closes the record, later words are dropped until a header
    task automatic close_record();
        push_result(KIND_SUMMARY, 64'd0);
        rec_step = WAIT_HEADER;
    endtask

    // advance the parser by one accepted word
    task automatic parse_record_word(input logic [63:0] w, input logic start);
        logic [12:0] total;
        logic [63:0] room;
        logic [63:0] limit;
        logic [63:0] cnt;
        total = rec_size[15:3];
        if (start) begin
            // a header always restarts, an open record is dropped silently
            rec_size   = w[63:48];
            held_ip    = '0;
            held_pid   = '0;
            held_tid   = '0;
            copy_count = '0;
            copied     = '0;
            entry_pos  = '0;
            emitted    = '0;
            rec_step   = READ_IP;
            if (w[63:51] < 13'd2) begin
                close_record();
            end
        end else begin
            case (rec_step)
                READ_IP: begin
                    held_ip = w;
                    if (total < 13'd3) close_record();
                    else rec_step = READ_PIDTID;
                end
                READ_PIDTID: begin
                    held_pid = w[31:0];
                    held_tid = w[63:32];
                    if (total < 13'd4) close_record();
                    else rec_step = READ_COUNT;
                end
                READ_COUNT: begin
                    // entries that fit: three words each in branch mode
                    if (cfg_branch) room = (64'(rec_size) - 64'd32) / 64'd24;
                    else room = 64'(total) - 64'd4;
                    limit = (cfg_max_depth < DEPTH_CAP) ? 64'(cfg_max_depth) : 64'(DEPTH_CAP);
                    cnt   = (w < room) ? w : room;
                    if (cnt > limit) cnt = limit;
                    copy_count = cnt[7:0];
                    copied     = '0;
                    entry_pos  = '0;
                    if (copy_count == 8'd0) close_record();
                    else rec_step = cfg_branch ? COPY_BRANCH : COPY_PLAIN;
                end
                COPY_PLAIN: begin
                    emitted++;
                    push_result(KIND_ADDR, w);
                    copied++;
                    if (copied == copy_count) close_record();
                end
                COPY_BRANCH: begin
                    if (entry_pos == 2'd0) begin
                        // only nonzero 'from' words become addresses
                        if (w != 64'd0) begin
                            emitted++;
                            push_result(KIND_ADDR, w);
                        end
                        copied++;
                        if (copied == copy_count) close_record();
                        else entry_pos = 2'd1;
                    end else if (entry_pos == 2'd1) begin
                        entry_pos = 2'd2;
                    end else begin
                        entry_pos = 2'd0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // one word transaction, with a random gap in front of it
    task automatic send_word(input logic [63:0] w, input logic start);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = w;
        s_axis_tuser  = start;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_record_word(w, start);
        words_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait out every owed result, then the unit's pipeline
    task automatic wait_for_results();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes only happen once the unit has gone quiet
    task automatic cfg_write(input logic idx, input logic [7:0] value);
        hold_input();
        wait_for_results();
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wen   = 1'b0;
        if (idx == CFG_BRANCH_MODE) cfg_branch = value[0];
        else cfg_max_depth = value;
    endtask

    // branch_mode only looks at bit 0, so the upper bits carry junk
    task automatic set_mode(input logic branch, input logic [7:0] depth);
        logic [7:0] junk;
        junk = 8'($urandom);
        cfg_write(CFG_BRANCH_MODE, {junk[7:1], branch});
        cfg_write(CFG_MAX_DEPTH, depth);
    endtask

    // header, ip, pid/tid, count, then entry words; cut or padded by n_words
    task automatic send_record(input int unsigned size, input logic [63:0] count_word,
                               input int unsigned n_words, input int unsigned zero_pct);
        logic [63:0] w;
        w = rand64();
        w[63:48] = size[15:0];
        send_word(w, 1'b1);
        records_sent++;
        for (int unsigned i = 1; i < n_words; i++) begin
            if (i == 3) w = count_word;
            else if (i >= 4 && $urandom_range(99) < zero_pct) w = '0;
            else w = rand64();
            send_word(w, 1'b0);
        end
    endtask

    // mostly well-formed records of small size, with a share of short,
    // oversized, truncated and padded ones and a few stray words
    task automatic random_record();
        int unsigned sel;
        int unsigned room;
        int unsigned body;
        int unsigned size;
        int unsigned n_words;
        int unsigned pick;
        logic [63:0] count_word;
        sel  = $urandom_range(99);
        if ($urandom_range(99) < 5) send_word(rand64(), 1'b0);
        room = ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(cfg_branch ? 12 : 40, 9);
        body = cfg_branch ? room * 3 + $urandom_range(2) : room;
        size = 32 + body * 8 + $urandom_range(7);
        pick = $urandom_range(99);
        if (pick < 10) count_word = '0;
        else if (pick < 20) count_word = rand64();
        else if (pick < 35) count_word = 64'(room + $urandom_range(6, 1));
        else count_word = 64'($urandom_range(room));
        n_words = 4 + body;
        if (sel < 8) begin
            // too short for some field
            size    = $urandom_range(31);
            n_words = (size < 16) ? 1 : size / 8;
        end else if (sel < 11) begin
            // stated size far beyond what is sent, cut off by the next header
            size    = $urandom_range(65535, 32);
            n_words = $urandom_range(12, 1);
        end else if (sel < 21) begin
            n_words += $urandom_range(3, 1);
        end else if (sel < 31) begin
            n_words = $urandom_range(n_words - 1, 1);
        end
        send_record(size, count_word, n_words, cfg_branch ? 30 : 10);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset configuration: plain words, depth 127
    task automatic test_directed_plain();
        send_word(rand64(), 1'b0);                          // stray word, no record open
        send_word({16'd0, 48'hFFFF_FFFF_FFFF}, 1'b1);       // size zero, summary on header
        send_word({16'd23, 48'd0}, 1'b1);                   // only the ip fits
        send_word('1, 1'b0);
        send_word({16'd31, 48'h5A5A_0F0F_3C3C}, 1'b1);      // ends on the pid/tid word
        send_word(rand64(), 1'b0);
        send_word(64'hFFFF_FFFF_0000_0000, 1'b0);
        send_record(32, 64'd5, 4, 0);                        // no room, summary on count
        send_word({16'd61, 48'h0}, 1'b1);                   // room 3, count saturates
        send_word(rand64(), 1'b0);
        send_word(64'h0000_0000_FFFF_FFFF, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);                          // past the end, ignored
        send_word({16'hFFFF, 48'hFFFF_FFFF_FFFF}, 1'b1);    // largest size, cut short
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        send_word(64'd2, 1'b0);
        send_word(rand64(), 1'b0);
        send_word({16'd15, 48'd0}, 1'b1);                   // header mid-record
    endtask

    task automatic test_branch_entries();
        set_mode(1'b1, MAX_DEPTH_RESET);
        // two entries: a zero 'from' is skipped, the last one also closes
        send_word({16'd88, 48'h1234_5678_9ABC}, 1'b1);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        send_word(64'd2, 1'b0);
        send_word('0, 1'b0);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        send_word(rand64() | 64'd1, 1'b0);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        // 55 bytes hold no whole branch entry
        send_record(55, 64'd9, 5, 0);
    endtask

    task automatic test_depth_limits();
        set_mode(1'b0, 8'd0);
        send_record(64, 64'd3, 8, 0);                        // depth zero, summary on count
        set_mode(1'b0, 8'd255);
        send_record(32 + 300 * 8, 64'd300, 304, 5);          // capped at 255 entries
        set_mode(1'b1, 8'd1);
        send_record(32 + 12 * 8, 64'd4, 16, 0);              // one branch entry only
    endtask

    task automatic test_random_mix();
        logic [7:0]  depth_pick [8] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd127, 8'd6, 8'd254, 8'd9};
        int unsigned target;
        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph[0], (ph == 7) ? 8'($urandom_range(255)) : depth_pick[ph]);
            target = words_sent + 100;
            while (words_sent < target) random_record();
            // size-zero header closes anything left open
            send_word(rand64() >> 16, 1'b1);
        end
    endtask

    // long run with neither side stalling
    task automatic test_back_to_back();
        int unsigned target;
        set_mode(1'($urandom_range(1)), 8'($urandom_range(255, 3)));
        steady_flow = 1'b1;
        target = words_sent + 150;
        while (words_sent < target) random_record();
        send_word({16'd0, 48'd0}, 1'b1);
        hold_input();
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %0s at cycle %0d: got %h, expected %h",
                     what, cycle_count, got, want);
    endtask

    // random backpressure, set up at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // every output transaction is matched against the oldest owed result
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tuser[0] !== want.kind)
                    report_mismatch("result_kind", 64'(m_axis_tuser), 64'(want.kind));
                if (m_axis_tdata[63:0] !== want.addr)
                    report_mismatch("stack_address", m_axis_tdata[63:0], want.addr);
                if (m_axis_tdata[127:64] !== want.ip)
                    report_mismatch("sample_ip", m_axis_tdata[127:64], want.ip);
                if (m_axis_tdata[159:128] !== want.pid)
                    report_mismatch("process_id", 64'(m_axis_tdata[159:128]), 64'(want.pid));
                if (m_axis_tdata[191:160] !== want.tid)
                    report_mismatch("thread_id", 64'(m_axis_tdata[191:160]), 64'(want.tid));
                if (m_axis_tdata[199:192] !== want.depth)
                    report_mismatch("stack_depth", 64'(m_axis_tdata[199:192]),
                                    64'(want.depth));
                if (m_axis_tlast !== want.done)
                    report_mismatch("record_done", 64'(m_axis_tlast), 64'(want.done));
                if (want.kind == KIND_SUMMARY) summaries_seen++;
                else addrs_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, results_due.size());
            $display("sample_record_callchain_parser_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_plain();
        test_branch_entries();
        test_depth_limits();
        test_random_mix();
        test_back_to_back();

        // drain, then give stray results a chance to show up
        hold_input();
        wait_for_results();

        $display("sent %0d record words in %0d records, both entry modes, depth 0 to 255",
                 words_sent, records_sent);
        $display("checked %0d stack addresses and %0d record summaries, %0d mismatches",
                 addrs_checked, summaries_seen, mismatches);
        if (mismatches == 0) begin
            $display("sample_record_callchain_parser_unit verification clean");
        end else begin
            $display("sample_record_callchain_parser_unit verification failed");
        end
        $finish;
    end

endmodule
